// File: hdl/assert_macros.svh
// Assertion helpers used by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset
`define FFA_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent
`define FFA_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/ffa_pkg.sv
package ffa_pkg;

   localparam int FFA_MAX_SEGMENTS = 64;
   localparam int FFA_ADDRESS_BITS = 16;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [2:0] STATUS_OK        = 3'd0;
   localparam logic [2:0] STATUS_ZERO_SIZE = 3'd1;
   localparam logic [2:0] STATUS_NO_MEMORY = 3'd2;
   localparam logic [2:0] STATUS_TABLE_FULL = 3'd3;
   localparam logic [2:0] STATUS_UNKNOWN   = 3'd4;

   typedef enum logic [8:0] {
      ST_IDLE      = 9'b000000001,
      ST_SCAN_RD   = 9'b000000010,
      ST_SCAN_CHK  = 9'b000000100,
      ST_RIGHT_CHK = 9'b000001000,
      ST_SHIFT_RD  = 9'b000010000,
      ST_SHIFT_WR  = 9'b000100000,
      ST_TAIL_WR   = 9'b001000000,
      ST_DONE      = 9'b010000000,
      ST_SPARE     = 9'b100000000
   } fsm_state_type;

endpackage

// File: hdl/ffa_mem.sv
module ffa_mem #(
   parameter int DEPTH     = 64,
   parameter int DATA_BITS = 34
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [$clog2(DEPTH)-1:0]     wr_addr,
   input  logic [DATA_BITS-1:0]         wr_data,
   input  logic                         rd_en,
   input  logic [$clog2(DEPTH)-1:0]     rd_addr,
   output logic [DATA_BITS-1:0]         rd_data
);

   logic [DATA_BITS-1:0] mem_ff [DEPTH];
   logic [DATA_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/ffa_ctrl.sv
module ffa_ctrl #(
   parameter int MAX_SEGMENTS = 64,
   parameter int ADDRESS_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic                    start_opcode,
   input  logic [ADDRESS_BITS-1:0] start_size,
   input  logic [ADDRESS_BITS-1:0] start_addr,
   input  logic [ADDRESS_BITS:0]   heap_limit,
   output logic                    idle,
   output logic                    done,
   output logic [2:0]              res_status,
   output logic [ADDRESS_BITS-1:0] res_address,
   output logic [ADDRESS_BITS:0]   res_size
);
   import ffa_pkg::*;

   localparam int AB = ADDRESS_BITS;
   localparam int IW = $clog2(MAX_SEGMENTS);
   localparam int CW = $clog2(MAX_SEGMENTS + 1);
   localparam int DW = 2 * AB + 2;
   localparam logic [CW-1:0] COUNT_MAX = CW'(MAX_SEGMENTS);
   localparam logic [AB:0] SPACE = {1'b1, {AB{1'b0}}};

   fsm_state_type state_ff, state_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AB:0]   heap_end_ff, heap_end_in;
   logic          op_ff, op_in;
   logic [AB-1:0] req_size_ff, req_size_in;
   logic [AB-1:0] addr_ff, addr_in;
   logic [AB-1:0] cur_start_ff, cur_start_in;
   logic [AB:0]   cur_size_ff, cur_size_in;
   logic [AB-1:0] prev_start_ff, prev_start_in;
   logic [AB:0]   prev_size_ff, prev_size_in;
   logic          prev_free_ff, prev_free_in;
   logic          has_right_ff, has_right_in;
   logic [CW-1:0] sh_dst_ff, sh_dst_in;
   logic [1:0]    sh_n_ff, sh_n_in;
   logic          sh_up_ff, sh_up_in;
   logic [CW-1:0] tail_pos_ff, tail_pos_in;
   logic [AB-1:0] tail_start_ff, tail_start_in;
   logic [AB:0]   tail_size_ff, tail_size_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [AB-1:0] res_address_ff, res_address_in;
   logic [AB:0]   res_size_ff, res_size_in;

   logic          mem_we, mem_re;
   logic [IW-1:0] mem_waddr, mem_raddr;
   logic [DW-1:0] mem_wdata, mem_rdata;

   logic [AB-1:0] rd_start;
   logic [AB:0]   rd_size;
   logic          rd_free;
   logic [AB:0]   req_ext;
   logic [AB:0]   lim;
   logic [AB+1:0] append_end;
   logic          fit, split, hit, rfree, lfree;
   logic [AB:0]   merged;
   logic [CW:0]   sh_src;

   ffa_mem #(
      .DEPTH     (MAX_SEGMENTS),
      .DATA_BITS (DW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign rd_start   = mem_rdata[DW-1 -: AB];
   assign rd_size    = mem_rdata[AB+1:1];
   assign rd_free    = mem_rdata[0];
   assign req_ext    = {1'b0, req_size_ff};
   assign lim        = (heap_limit > SPACE) ? SPACE : heap_limit;
   assign append_end = {1'b0, heap_end_ff} + {1'b0, req_ext};
   assign fit        = rd_free && (rd_size >= req_ext);
   assign split      = (rd_size > req_ext) && (count_ff != COUNT_MAX);
   assign hit        = !rd_free && (rd_start == addr_ff);
   assign rfree      = has_right_ff && rd_free;
   assign lfree      = (idx_ff != '0) && prev_free_ff;
   assign merged     = cur_size_ff + (rfree ? rd_size : '0) + (lfree ? prev_size_ff : '0);
   assign sh_src     = {1'b0, sh_dst_ff} + {{(CW - 1){1'b0}}, sh_n_ff};

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      heap_end_in    = heap_end_ff;
      op_in          = op_ff;
      req_size_in    = req_size_ff;
      addr_in        = addr_ff;
      cur_start_in   = cur_start_ff;
      cur_size_in    = cur_size_ff;
      prev_start_in  = prev_start_ff;
      prev_size_in   = prev_size_ff;
      prev_free_in   = prev_free_ff;
      has_right_in   = has_right_ff;
      sh_dst_in      = sh_dst_ff;
      sh_n_in        = sh_n_ff;
      sh_up_in       = sh_up_ff;
      tail_pos_in    = tail_pos_ff;
      tail_start_in  = tail_start_ff;
      tail_size_in   = tail_size_ff;
      res_status_in  = res_status_ff;
      res_address_in = res_address_ff;
      res_size_in    = res_size_ff;
      mem_we         = 1'b0;
      mem_waddr      = '0;
      mem_wdata      = '0;
      mem_re         = 1'b0;
      mem_raddr      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in          = start_opcode;
               req_size_in    = start_size;
               addr_in        = start_addr;
               idx_in         = '0;
               res_status_in  = STATUS_OK;
               res_address_in = '0;
               res_size_in    = '0;
               if (start_opcode == OP_ALLOC && start_size == '0) begin
                  res_status_in = STATUS_ZERO_SIZE;
                  state_in      = ST_DONE;
               end else begin
                  state_in = ST_SCAN_RD;
               end
            end
         end
         ST_SCAN_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_DONE;
               if (op_ff == OP_FREE) begin
                  res_status_in = STATUS_UNKNOWN;
               end else if (append_end > {1'b0, lim}) begin
                  res_status_in = STATUS_NO_MEMORY;
               end else if (count_ff == COUNT_MAX) begin
                  res_status_in = STATUS_TABLE_FULL;
               end else begin
                  // append a new segment at the heap end
                  mem_we         = 1'b1;
                  mem_waddr      = count_ff[IW-1:0];
                  mem_wdata      = {heap_end_ff[AB-1:0], req_ext, 1'b0};
                  count_in       = count_ff + 1'b1;
                  heap_end_in    = append_end[AB:0];
                  res_address_in = heap_end_ff[AB-1:0];
                  res_size_in    = req_ext;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = idx_ff[IW-1:0];
               state_in  = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (op_ff == OP_ALLOC && fit) begin
               mem_we         = 1'b1;
               mem_waddr      = idx_ff[IW-1:0];
               mem_wdata      = {rd_start, (split ? req_ext : rd_size), 1'b0};
               res_address_in = rd_start;
               res_size_in    = split ? req_ext : rd_size;
               if (split) begin
                  tail_pos_in   = idx_ff + 1'b1;
                  tail_start_in = rd_start + req_size_ff;
                  tail_size_in  = rd_size - req_ext;
                  sh_dst_in     = count_ff;
                  sh_up_in      = 1'b1;
                  sh_n_in       = 2'd1;
                  state_in      = ST_SHIFT_RD;
               end else begin
                  state_in = ST_DONE;
               end
            end else if (op_ff == OP_FREE && hit) begin
               cur_start_in = rd_start;
               cur_size_in  = rd_size;
               has_right_in = (idx_ff + 1'b1) < count_ff;
               if ((idx_ff + 1'b1) < count_ff) begin
                  mem_re    = 1'b1;
                  mem_raddr = IW'(idx_ff + 1'b1);
               end
               state_in = ST_RIGHT_CHK;
            end else begin
               // keep the left neighbor for a later merge
               prev_start_in = rd_start;
               prev_size_in  = rd_size;
               prev_free_in  = rd_free;
               idx_in        = idx_ff + 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_RIGHT_CHK: begin
            mem_we    = 1'b1;
            mem_waddr = lfree ? IW'(idx_ff - 1'b1) : idx_ff[IW-1:0];
            mem_wdata = {(lfree ? prev_start_ff : cur_start_ff), merged, 1'b1};
            res_address_in = lfree ? prev_start_ff : cur_start_ff;
            res_size_in    = merged;
            if (!rfree && !lfree) begin
               state_in = ST_DONE;
            end else begin
               sh_dst_in = lfree ? idx_ff : idx_ff + 1'b1;
               sh_n_in   = {1'b0, rfree} + {1'b0, lfree};
               sh_up_in  = 1'b0;
               state_in  = ST_SHIFT_RD;
            end
         end
         ST_SHIFT_RD: begin
            if (sh_up_ff) begin
               if (sh_dst_ff == tail_pos_ff) begin
                  state_in = ST_TAIL_WR;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = IW'(sh_dst_ff - 1'b1);
                  state_in  = ST_SHIFT_WR;
               end
            end else begin
               if (sh_src >= {1'b0, count_ff}) begin
                  count_in = count_ff - CW'(sh_n_ff);
                  state_in = ST_DONE;
               end else begin
                  mem_re    = 1'b1;
                  mem_raddr = sh_src[IW-1:0];
                  state_in  = ST_SHIFT_WR;
               end
            end
         end
         ST_SHIFT_WR: begin
            mem_we    = 1'b1;
            mem_waddr = sh_dst_ff[IW-1:0];
            mem_wdata = mem_rdata;
            sh_dst_in = sh_up_ff ? sh_dst_ff - 1'b1 : sh_dst_ff + 1'b1;
            state_in  = ST_SHIFT_RD;
         end
         ST_TAIL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = tail_pos_ff[IW-1:0];
            mem_wdata = {tail_start_ff, tail_size_ff, 1'b1};
            count_in  = count_ff + 1'b1;
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         count_ff    <= '0;
         heap_end_ff <= '0;
      end else begin
         state_ff    <= state_in;
         count_ff    <= count_in;
         heap_end_ff <= heap_end_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      op_ff          <= op_in;
      req_size_ff    <= req_size_in;
      addr_ff        <= addr_in;
      cur_start_ff   <= cur_start_in;
      cur_size_ff    <= cur_size_in;
      prev_start_ff  <= prev_start_in;
      prev_size_ff   <= prev_size_in;
      prev_free_ff   <= prev_free_in;
      has_right_ff   <= has_right_in;
      sh_dst_ff      <= sh_dst_in;
      sh_n_ff        <= sh_n_in;
      sh_up_ff       <= sh_up_in;
      tail_pos_ff    <= tail_pos_in;
      tail_start_ff  <= tail_start_in;
      tail_size_ff   <= tail_size_in;
      res_status_ff  <= res_status_in;
      res_address_ff <= res_address_in;
      res_size_ff    <= res_size_in;
   end

   assign idle        = (state_ff == ST_IDLE);
   assign done        = (state_ff == ST_DONE);
   assign res_status  = res_status_ff;
   assign res_address = res_address_ff;
   assign res_size    = res_size_ff;

endmodule

// File: hdl/first_fit_segment_allocator_top.sv
// Each entry moved by a split or a merge costs a read and a write; a closing step ends each request.
// Each scanned entry costs a read and a check, since the segment table memory has a registered read.
// One item in flight; the next item is taken once the result register is empty.
// Reset (synchronous): empty table, heap end 0, heap_limit 2^ADDRESS_BITS; no clearing pass.
`include "assert_macros.svh"

module first_fit_segment_allocator_top #(
   parameter int MAX_SEGMENTS = ffa_pkg::FFA_MAX_SEGMENTS,
   parameter int ADDRESS_BITS = ffa_pkg::FFA_ADDRESS_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [ADDRESS_BITS:0]   csr_heap_limit,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic                    req_opcode,
   input  logic [ADDRESS_BITS-1:0] req_alloc_size,
   input  logic [ADDRESS_BITS-1:0] req_free_address,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [2:0]              rsp_status,
   output logic [ADDRESS_BITS-1:0] rsp_block_address,
   output logic [ADDRESS_BITS:0]   rsp_block_size
);
   import ffa_pkg::*;

   localparam int AB = ADDRESS_BITS;

   logic [AB:0]   heap_limit_ff, heap_limit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [2:0]    rsp_status_ff;
   logic [AB-1:0] rsp_address_ff;
   logic [AB:0]   rsp_size_ff;
   logic          ctrl_idle, ctrl_done;
   logic [2:0]    res_status;
   logic [AB-1:0] res_address;
   logic [AB:0]   res_size;
   logic          fail_fields_ok;

   assign csr_ready     = 1'b1;
   assign heap_limit_in = (csr_valid && csr_ready) ? csr_heap_limit : heap_limit_ff;
   assign req_ready     = ctrl_idle && !rsp_valid_ff;

   ffa_ctrl #(
      .MAX_SEGMENTS (MAX_SEGMENTS),
      .ADDRESS_BITS (ADDRESS_BITS)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .start        (req_valid && req_ready),
      .start_opcode (req_opcode),
      .start_size   (req_alloc_size),
      .start_addr   (req_free_address),
      .heap_limit   (heap_limit_ff),
      .idle         (ctrl_idle),
      .done         (ctrl_done),
      .res_status   (res_status),
      .res_address  (res_address),
      .res_size     (res_size)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl_done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         heap_limit_ff <= {1'b1, {AB{1'b0}}};
         rsp_valid_ff  <= 1'b0;
      end else begin
         heap_limit_ff <= heap_limit_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // hold the result until the item is taken
   always_ff @(posedge clock) begin
      if (ctrl_done) begin
         rsp_status_ff  <= res_status;
         rsp_address_ff <= res_address;
         rsp_size_ff    <= res_size;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_block_address = rsp_address_ff;
   assign rsp_block_size    = rsp_size_ff;

   assign fail_fields_ok = !(rsp_valid_ff && rsp_status_ff != STATUS_OK) ||
                           (rsp_address_ff == '0 && rsp_size_ff == '0);

   `FFA_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)
   `FFA_ASSERT_ALWAYS(a_no_result_overwrite, clock, reset, !(ctrl_done && rsp_valid_ff))
   `FFA_ASSERT_ALWAYS(a_fail_fields_zero, clock, reset, fail_fields_ok)

endmodule
